/* rtl/mvsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mvsp_pkg;

    typedef enum logic [4:0] {
        PH_SCAN,
        PH_RA_TYPE,
        PH_OLID,
        PH_VERID,
        PH_ASPECT,
        PH_PAR,
        PH_CTRL,
        PH_CHROMA,
        PH_VBVFLAG,
        PH_VBV,
        PH_SHAPE,
        PH_RES,
        PH_MARK1,
        PH_FIXED,
        PH_INCR,
        PH_MARK2,
        PH_WIDTH,
        PH_MARK3,
        PH_HEIGHT,
        PH_DONE
    } mvsp_phase_t;

    typedef struct packed {
        mvsp_phase_t phase;
        logic [6:0]  bits_left;
        logic [15:0] acc;
        logic [4:0]  incr_bits;
        logic [12:0] width_hold;
    } mvsp_state_t;

    localparam logic [31:0] VOL_CODE_MASK = 32'h0000_000F;
    localparam logic [31:0] VOL_CODE_BASE = 32'h0000_0120;
    localparam logic [31:0] WINDOW_RESET  = 32'hFFFF_FFFF;
    localparam logic [3:0]  ASPECT_EXT    = 4'd15;
    localparam logic [6:0]  RA_TYPE_BITS  = 7'd9;
    localparam logic [6:0]  VERID_BITS    = 7'd7;
    localparam logic [6:0]  ASPECT_BITS   = 7'd4;
    localparam logic [6:0]  PAR_BITS      = 7'd16;
    localparam logic [6:0]  CHROMA_BITS   = 7'd3;
    localparam logic [6:0]  VBV_BITS      = 7'(15 + 1 + 15 + 1 + 15 + 1 + 3 + 11 + 1 + 15 + 1);
    localparam logic [6:0]  SHAPE_BITS    = 7'd3;
    localparam logic [6:0]  RES_BITS      = 7'd16;
    localparam logic [6:0]  SIZE_BITS     = 7'd13;
    localparam logic [6:0]  FLAG_BITS     = 7'd1;

    localparam mvsp_state_t STATE_RESET = '{
        phase:      PH_SCAN,
        bits_left:  7'd0,
        acc:        16'd0,
        incr_bits:  5'd0,
        width_hold: 13'd0
    };

    function automatic mvsp_state_t enter_phase(input mvsp_state_t st,
                                                input mvsp_phase_t ph,
                                                input logic [6:0] nbits);
        mvsp_state_t r;
        r           = st;
        r.phase     = ph;
        r.bits_left = nbits;
        r.acc       = '0;
        return r;
    endfunction

    // number of significant bits, 0 for zero
    function automatic logic [4:0] bit_length16(input logic [15:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                n = 5'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/mvsp_bit_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module mvsp_bit_step (
    input  mvsp_pkg::mvsp_state_t st_i,
    input  logic                  bit_i,
    output mvsp_pkg::mvsp_state_t st_o,
    output logic                  hit_o
);
    import mvsp_pkg::*;

    logic [15:0] acc_n;
    logic [6:0]  bl_n;
    logic [4:0]  res_len;
    mvsp_state_t st_sh;

    always_comb begin
        acc_n   = {st_i.acc[14:0], bit_i};
        bl_n    = (st_i.bits_left != 7'd0) ? st_i.bits_left - 7'd1 : 7'd0;
        res_len = bit_length16(acc_n - 16'd1);
        st_sh           = st_i;
        st_sh.acc       = acc_n;
        st_sh.bits_left = bl_n;
        st_o  = st_i;
        hit_o = 1'b0;
        // scanning and finished phases consume no header bits
        if (st_i.phase != PH_SCAN && st_i.phase != PH_DONE) begin
            st_o = st_sh;
            if (bl_n == 7'd0) begin
                case (st_i.phase)
                    PH_RA_TYPE: st_o = enter_phase(st_sh, PH_OLID, FLAG_BITS);
                    PH_OLID: begin
                        if (acc_n[0]) st_o = enter_phase(st_sh, PH_VERID, VERID_BITS);
                        else          st_o = enter_phase(st_sh, PH_ASPECT, ASPECT_BITS);
                    end
                    PH_VERID:   st_o = enter_phase(st_sh, PH_ASPECT, ASPECT_BITS);
                    PH_ASPECT: begin
                        if (acc_n[3:0] == ASPECT_EXT) begin
                            st_o = enter_phase(st_sh, PH_PAR, PAR_BITS);
                        end else begin
                            st_o = enter_phase(st_sh, PH_CTRL, FLAG_BITS);
                        end
                    end
                    PH_PAR:     st_o = enter_phase(st_sh, PH_CTRL, FLAG_BITS);
                    PH_CTRL: begin
                        if (acc_n[0]) st_o = enter_phase(st_sh, PH_CHROMA, CHROMA_BITS);
                        else          st_o = enter_phase(st_sh, PH_SHAPE, SHAPE_BITS);
                    end
                    PH_CHROMA:  st_o = enter_phase(st_sh, PH_VBVFLAG, FLAG_BITS);
                    PH_VBVFLAG: begin
                        if (acc_n[0]) st_o = enter_phase(st_sh, PH_VBV, VBV_BITS);
                        else          st_o = enter_phase(st_sh, PH_SHAPE, SHAPE_BITS);
                    end
                    PH_VBV:     st_o = enter_phase(st_sh, PH_SHAPE, SHAPE_BITS);
                    PH_SHAPE:   st_o = enter_phase(st_sh, PH_RES, RES_BITS);
                    PH_RES: begin
                        st_o = enter_phase(st_sh, PH_MARK1, FLAG_BITS);
                        st_o.incr_bits = (res_len == 5'd0) ? 5'd1 : res_len;
                    end
                    PH_MARK1:   st_o = enter_phase(st_sh, PH_FIXED, FLAG_BITS);
                    PH_FIXED: begin
                        if (acc_n[0]) begin
                            st_o = enter_phase(st_sh, PH_INCR, {2'b00, st_i.incr_bits});
                        end else begin
                            st_o = enter_phase(st_sh, PH_MARK2, FLAG_BITS);
                        end
                    end
                    PH_INCR:    st_o = enter_phase(st_sh, PH_MARK2, FLAG_BITS);
                    PH_MARK2:   st_o = enter_phase(st_sh, PH_WIDTH, SIZE_BITS);
                    PH_WIDTH: begin
                        st_o = enter_phase(st_sh, PH_MARK3, FLAG_BITS);
                        st_o.width_hold = acc_n[12:0];
                    end
                    PH_MARK3:   st_o = enter_phase(st_sh, PH_HEIGHT, SIZE_BITS);
                    PH_HEIGHT: begin
                        st_o.phase = PH_DONE;
                        hit_o      = 1'b1;
                    end
                    default:    st_o.phase = PH_DONE;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/mvsp_byte_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module mvsp_byte_unit (
    input  mvsp_pkg::mvsp_state_t st_i,
    input  logic [31:0]           win_i,
    input  logic [7:0]            byte_i,
    output mvsp_pkg::mvsp_state_t st_o,
    output logic [31:0]           win_o,
    output logic                  hit_o
);
    import mvsp_pkg::*;

    mvsp_state_t chain [0:8];
    logic [7:0]  hits;
    logic [31:0] win_sh;

    assign chain[0] = st_i;

    // msb first; once the height completes the later steps just hold
    for (genvar k = 0; k < 8; k++) begin : g_step
        mvsp_bit_step u_step (
            .st_i  (chain[k]),
            .bit_i (byte_i[7 - k]),
            .st_o  (chain[k + 1]),
            .hit_o (hits[k])
        );
    end

    always_comb begin
        win_sh = {win_i[23:0], byte_i};
        st_o   = chain[8];
        win_o  = win_i;
        hit_o  = |hits;
        if (st_i.phase == PH_SCAN) begin
            win_o = win_sh;
            hit_o = 1'b0;
            st_o  = st_i;
            if ((win_sh & ~VOL_CODE_MASK) == VOL_CODE_BASE) begin
                st_o = enter_phase(st_i, PH_RA_TYPE, RA_TYPE_BITS);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/mpeg4_vol_size_parser_core.sv */
// a taken byte is registered in in_byte_reg and parsed once the output register is free;
//   its result, if any, is registered in the output register and shows on m_tvalid
// throughput: one byte per cycle unless a result waits on m_tready, eight header bits walked per byte in one pass
// a result per buffer: found with size on the last height bit, else found=0 on tlast
// reset (aresetn low, synchronous) clears the input and output valid flags and rearms the scan
`timescale 1ns / 1ps
`default_nettype none

module mpeg4_vol_size_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // frame_width[12:0], frame_height[25:13]
    output logic             m_tuser    // found
);
    import mvsp_pkg::*;

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    mvsp_state_t st_reg, st_next, st_proc;
    logic [31:0] win_reg, win_next, win_proc;
    logic        hit;
    logic        out_vld_reg, out_vld_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        out_found_reg, out_found_next;
    logic        can_proc, proc, emit;

    mvsp_byte_unit u_byte (
        .st_i   (st_reg),
        .win_i  (win_reg),
        .byte_i (in_byte_reg),
        .st_o   (st_proc),
        .win_o  (win_proc),
        .hit_o  (hit)
    );

    assign can_proc = !out_vld_reg || m_tready;
    assign proc     = in_vld_reg && can_proc;
    assign s_tready = !in_vld_reg || can_proc;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_found_reg;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tready) begin
            in_vld_next = s_tvalid;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end

        st_next  = st_reg;
        win_next = win_reg;
        if (proc) begin
            if (in_last_reg) begin
                st_next  = STATE_RESET;
                win_next = WINDOW_RESET;
            end else begin
                st_next  = st_proc;
                win_next = win_proc;
            end
        end

        // a buffer that ends without a header still gets one found=0 result
        emit = hit || (in_last_reg && st_proc.phase != PH_DONE);
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        out_found_next = out_found_reg;
        if (can_proc) begin
            out_vld_next   = proc && emit;
            out_found_next = hit;
            out_data_next  = hit ? {6'd0, st_proc.acc[12:0], st_proc.width_hold}
                                 : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= STATE_RESET;
            win_reg     <= WINDOW_RESET;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            st_reg      <= st_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_data_reg  <= out_data_next;
        out_found_reg <= out_found_next;
    end

    a_last_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_last_reg |=> st_reg.phase == PH_SCAN && win_reg == WINDOW_RESET)
        else $error("parser did not rearm after the last byte");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("size fields nonzero on a not-found result");

    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !can_proc |=> in_vld_reg && $stable(in_byte_reg))
        else $error("input byte dropped while output stalled");

    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && st_reg.phase == PH_DONE && !in_last_reg |=> !m_tvalid)
        else $error("result after header already reported");

endmodule

`default_nettype wire

/* dv/mpeg4_vol_size_parser_core_tb.sv */
`timescale 1ns / 1ps

module mpeg4_vol_size_parser_core_tb;
    import mvsp_pkg::*;

    localparam logic [31:0] CODE_MASK  = 32'h0000_000F;
    localparam logic [31:0] CODE_BASE  = 32'h0000_0120;
    localparam logic [3:0]  PAR_ESCAPE = 4'd15;
    localparam int          VBV_LEN    = 15 + 1 + 15 + 1 + 15 + 1 + 3 + 11 + 1 + 15 + 1;
    localparam int          BYTE_GOAL  = 1550;

    typedef struct packed {
        logic        found;
        logic [12:0] width;
        logic [12:0] height;
    } vol_size_t;

    typedef struct packed {
        logic [3:0]  code_lo;
        logic        rand_access;
        logic [7:0]  obj_type;
        logic        has_olid;
        logic [6:0]  verid_prio;
        logic [3:0]  aspect;
        logic [15:0] par;
        logic        has_ctrl;
        logic [2:0]  chroma;
        logic        has_vbv;
        logic [2:0]  shape;
        logic [15:0] res;
        logic        fixed_rate;
        logic [15:0] incr;
        logic [12:0] width;
        logic [12:0] height;
    } vol_hdr_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // parser state as the predictor sees it
    logic [31:0] ps_window;
    mvsp_phase_t ps_phase;
    logic [6:0]  ps_left;
    logic [15:0] ps_acc;
    logic [4:0]  ps_incr;
    logic [12:0] ps_width;
    logic        ps_done;

    vol_size_t   expected_sizes[$];
    vol_size_t   exp_size;
    logic [7:0]  stream[$];
    bit          hdr_bits[$];
    int          vol_end;
    int          bytes_sent = 0;
    int          errors = 0;
    bit          idle_off = 1'b0;
    int          rx_hold = 0;

    mpeg4_vol_size_parser_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5ms;
        $display("mpeg4_vol_size_parser_core_tb: errors");
        $finish;
    end

    // ---------------- size predictor ----------------

    function automatic logic [4:0] sig_bits(input logic [15:0] x);
        logic [4:0] n;
        n = 5'd0;
        while (x != 16'd0) begin
            n = n + 5'd1;
            x = x >> 1;
        end
        return n;
    endfunction

    // length of fixed_vop_time_increment for a given resolution
    function automatic logic [4:0] incr_len(input logic [15:0] res);
        logic [4:0] n;
        n = sig_bits(res - 16'd1);
        return (n == 5'd0) ? 5'd1 : n;
    endfunction

    function automatic void clear_parser();
        ps_window = 32'hFFFF_FFFF;
        ps_phase  = PH_SCAN;
        ps_left   = 7'd0;
        ps_acc    = 16'd0;
        ps_incr   = 5'd0;
        ps_width  = 13'd0;
        ps_done   = 1'b0;
    endfunction

    function automatic void open_field(input mvsp_phase_t ph, input logic [6:0] n);
        ps_phase = ph;
        ps_left  = n;
        ps_acc   = 16'd0;
    endfunction

    // shift one header bit in; returns 1 when the height just completed
    function automatic logic walk_bit(input logic b);
        logic [15:0] v;
        ps_acc = {ps_acc[14:0], b};
        if (ps_left != 7'd0) begin
            ps_left = ps_left - 7'd1;
        end
        if (ps_left != 7'd0) begin
            return 1'b0;
        end
        v = ps_acc;
        case (ps_phase)
            PH_RA_TYPE: open_field(PH_OLID, 7'd1);
            PH_OLID: begin
                if (v[0]) open_field(PH_VERID, 7'd7);
                else open_field(PH_ASPECT, 7'd4);
            end
            PH_VERID: open_field(PH_ASPECT, 7'd4);
            PH_ASPECT: begin
                if (v[3:0] == PAR_ESCAPE) open_field(PH_PAR, 7'd16);
                else open_field(PH_CTRL, 7'd1);
            end
            PH_PAR: open_field(PH_CTRL, 7'd1);
            PH_CTRL: begin
                if (v[0]) open_field(PH_CHROMA, 7'd3);
                else open_field(PH_SHAPE, 7'd3);
            end
            PH_CHROMA: open_field(PH_VBVFLAG, 7'd1);
            PH_VBVFLAG: begin
                if (v[0]) open_field(PH_VBV, 7'(VBV_LEN));
                else open_field(PH_SHAPE, 7'd3);
            end
            PH_VBV: open_field(PH_SHAPE, 7'd3);
            PH_SHAPE: open_field(PH_RES, 7'd16);
            PH_RES: begin
                ps_incr = incr_len(v);
                open_field(PH_MARK1, 7'd1);
            end
            PH_MARK1: open_field(PH_FIXED, 7'd1);
            PH_FIXED: begin
                if (v[0]) open_field(PH_INCR, {2'b00, ps_incr});
                else open_field(PH_MARK2, 7'd1);
            end
            PH_INCR: open_field(PH_MARK2, 7'd1);
            PH_MARK2: open_field(PH_WIDTH, 7'd13);
            PH_WIDTH: begin
                ps_width = v[12:0];
                open_field(PH_MARK3, 7'd1);
            end
            PH_MARK3: open_field(PH_HEIGHT, 7'd13);
            PH_HEIGHT: begin
                ps_phase = PH_DONE;
                ps_done  = 1'b1;
                return 1'b1;
            end
            default: ps_phase = PH_DONE;
        endcase
        return 1'b0;
    endfunction

    task automatic predict_size(input logic [7:0] d, input logic last);
        logic hit;
        hit = 1'b0;
        if (!ps_done) begin
            if (ps_phase == PH_SCAN) begin
                ps_window = {ps_window[23:0], d};
                if ((ps_window & ~CODE_MASK) == CODE_BASE) begin
                    open_field(PH_RA_TYPE, 7'd9);
                end
            end else begin
                for (int i = 7; i >= 0 && !hit; i--) begin
                    hit = walk_bit(d[i]);
                end
            end
        end
        if (hit) begin
            expected_sizes.push_back({1'b1, ps_width, ps_acc[12:0]});
        end
        if (last) begin
            if (!ps_done) begin
                expected_sizes.push_back({1'b0, 13'd0, 13'd0});
            end
            clear_parser();
        end
    endtask

    // ---------------- result checker ----------------

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_sizes.size() == 0) begin
                $display("%0t: unexpected result transfer, got %h / %b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                exp_size = expected_sizes.pop_front();
                if (m_tuser !== exp_size.found) begin
                    $display("%0t: found expected %0d got %0d",
                             $time, exp_size.found, m_tuser);
                    errors++;
                end
                if (m_tdata[12:0] !== exp_size.width) begin
                    $display("%0t: width expected %0d got %0d",
                             $time, exp_size.width, m_tdata[12:0]);
                    errors++;
                end
                if (m_tdata[25:13] !== exp_size.height) begin
                    $display("%0t: height expected %0d got %0d",
                             $time, exp_size.height, m_tdata[25:13]);
                    errors++;
                end
            end
        end
    end

    // ---------------- result receiver ----------------

    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end else begin
                gap = idle_off ? 0 : $urandom_range(0, 3);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && rx_hold == 0);
        end
    end

    // ---------------- stream building and sending ----------------

    task automatic send_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_size(d, last);
        bytes_sent++;
    endtask

    // sends the first cut bytes of the built stream as one buffer
    task automatic send_stream(input int cut);
        for (int i = 0; i < cut; i++) begin
            send_byte(stream[i], i == cut - 1);
        end
        stream.delete();
    endtask

    task automatic push_junk(input int n);
        repeat (n) stream.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            hdr_bits.push_back(v[i]);
        end
    endtask

    task automatic put_marker();
        hdr_bits.push_back(1'($urandom_range(0, 1)));
    endtask

    task automatic push_vol(input vol_hdr_t h);
        logic [7:0] b;
        hdr_bits.delete();
        stream.push_back(8'h00);
        stream.push_back(8'h00);
        stream.push_back(8'h01);
        stream.push_back({4'h2, h.code_lo});
        put_bits(32'(h.rand_access), 1);
        put_bits(32'(h.obj_type), 8);
        put_bits(32'(h.has_olid), 1);
        if (h.has_olid) put_bits(32'(h.verid_prio), 7);
        put_bits(32'(h.aspect), 4);
        if (h.aspect == PAR_ESCAPE) put_bits(32'(h.par), 16);
        put_bits(32'(h.has_ctrl), 1);
        if (h.has_ctrl) begin
            put_bits(32'(h.chroma), 3);
            put_bits(32'(h.has_vbv), 1);
            if (h.has_vbv) repeat (VBV_LEN) put_marker();
        end
        put_bits(32'(h.shape), 3);
        put_bits(32'(h.res), 16);
        put_marker();
        put_bits(32'(h.fixed_rate), 1);
        if (h.fixed_rate) put_bits(32'(h.incr), int'(incr_len(h.res)));
        put_marker();
        put_bits(32'(h.width), 13);
        put_marker();
        put_bits(32'(h.height), 13);
        // fill the byte holding the last height bit
        while (hdr_bits.size() % 8 != 0) put_marker();
        for (int i = 0; i < hdr_bits.size(); i += 8) begin
            for (int j = 0; j < 8; j++) begin
                b[7 - j] = hdr_bits[i + j];
            end
            stream.push_back(b);
        end
        vol_end = stream.size();
    endtask

    function automatic logic [12:0] rand_dim();
        case ($urandom_range(0, 7))
            0: return 13'd0;
            1: return 13'h1FFF;
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    function automatic vol_hdr_t rand_vol();
        vol_hdr_t h;
        h.code_lo     = 4'($urandom_range(0, 15));
        h.rand_access = 1'($urandom_range(0, 1));
        h.obj_type    = 8'($urandom_range(0, 255));
        h.has_olid    = 1'($urandom_range(0, 1));
        h.verid_prio  = 7'($urandom_range(0, 127));
        h.aspect      = ($urandom_range(0, 2) == 0) ? PAR_ESCAPE : 4'($urandom_range(0, 15));
        h.par         = 16'($urandom_range(0, 65535));
        h.has_ctrl    = 1'($urandom_range(0, 1));
        h.chroma      = 3'($urandom_range(0, 7));
        h.has_vbv     = 1'($urandom_range(0, 1));
        h.shape       = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0: h.res = 16'd0;
            1: h.res = 16'd1;
            2: h.res = 16'hFFFF;
            default: h.res = 16'($urandom_range(0, 65535));
        endcase
        h.fixed_rate  = 1'($urandom_range(0, 1));
        h.incr        = 16'($urandom_range(0, 65535));
        h.width       = rand_dim();
        h.height      = rand_dim();
        return h;
    endfunction

    // ---------------- tests ----------------

    task automatic test_minimal_header();
        vol_hdr_t h;
        h = rand_vol();
        h.code_lo    = 4'h0;
        h.has_olid   = 1'b0;
        h.aspect     = 4'd1;
        h.has_ctrl   = 1'b0;
        h.fixed_rate = 1'b0;
        h.width      = 13'd0;
        h.height     = 13'd0;
        push_vol(h);
        send_stream(stream.size());
    endtask

    task automatic test_all_options();
        vol_hdr_t h;
        h = rand_vol();
        h.code_lo    = 4'hF;
        h.has_olid   = 1'b1;
        h.aspect     = PAR_ESCAPE;
        h.has_ctrl   = 1'b1;
        h.has_vbv    = 1'b1;
        h.fixed_rate = 1'b1;
        h.res        = 16'd0;
        h.width      = 13'h1FFF;
        h.height     = 13'h1FFF;
        push_junk(2);
        push_vol(h);
        push_junk(2);
        send_stream(stream.size());
        // control present but no vbv parameters
        h = rand_vol();
        h.has_ctrl = 1'b1;
        h.has_vbv  = 1'b0;
        push_vol(h);
        send_stream(stream.size());
    endtask

    task automatic test_increment_lengths();
        vol_hdr_t h;
        logic [15:0] res_list[4];
        res_list = '{16'd1, 16'd2, 16'hFFFF, 16'h8001};
        foreach (res_list[i]) begin
            h = rand_vol();
            h.res        = res_list[i];
            h.fixed_rate = 1'b1;
            push_vol(h);
            send_stream(vol_end);
        end
    endtask

    task automatic test_short_buffers();
        vol_hdr_t h;
        // header cut inside the height
        h = rand_vol();
        push_vol(h);
        send_stream(vol_end - 1);
        // buffer ends on the start code byte
        push_vol(rand_vol());
        send_stream(4);
        // single byte buffer, then a buffer with no start code
        push_junk(1);
        send_stream(1);
        push_junk(6);
        send_stream(6);
    endtask

    task automatic test_start_code_edges();
        // neighbors of the vol code range
        stream = '{8'h00, 8'h00, 8'h01, 8'h1F, 8'h00, 8'h00, 8'h01, 8'h30};
        push_junk(4);
        send_stream(stream.size());
        // code split over two buffers must not match
        stream = '{8'h5A, 8'h00, 8'h00};
        send_stream(3);
        stream = '{8'h01, 8'h20};
        push_junk(10);
        send_stream(stream.size());
    endtask

    task automatic test_trailing_ignored();
        // a second start code after the hit is dropped until the last byte
        push_vol(rand_vol());
        push_vol(rand_vol());
        send_stream(stream.size());
    endtask

    task automatic test_output_stall();
        idle_off = 1'b1;
        rx_hold  = 300;
        repeat (12) begin
            push_junk(3);
            send_stream(3);
        end
        push_vol(rand_vol());
        send_stream(stream.size());
        idle_off = 1'b0;
    endtask

    task automatic test_random_streams();
        int kind;
        int nbuf;
        nbuf = 0;
        while (bytes_sent < BYTE_GOAL) begin
            if (nbuf % 16 == 0) begin
                idle_off = ($urandom_range(0, 3) == 0);
            end
            nbuf++;
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                push_junk($urandom_range(0, 4));
                push_vol(rand_vol());
                push_junk($urandom_range(0, 4));
                if (kind == 6) send_stream($urandom_range(1, vol_end - 1));
                else send_stream(stream.size());
            end else if (kind == 7) begin
                push_junk($urandom_range(1, 12));
                send_stream(stream.size());
            end else begin
                // start code or near miss followed by garbage
                stream.push_back(8'h00);
                stream.push_back(8'h00);
                stream.push_back(8'h01);
                stream.push_back((kind == 8) ? 8'($urandom_range(32'h20, 32'h2F))
                                             : 8'($urandom_range(0, 255)));
                push_junk($urandom_range(0, 12));
                send_stream(stream.size());
            end
        end
        idle_off = 1'b0;
    endtask

    initial begin
        clear_parser();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_minimal_header();
        test_all_options();
        test_increment_lengths();
        test_short_buffers();
        test_start_code_edges();
        test_trailing_ignored();
        test_output_stall();
        test_random_streams();
        s_tvalid <= 1'b0;
        while (expected_sizes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("mpeg4_vol_size_parser_core_tb: clean");
        end else begin
            $display("mpeg4_vol_size_parser_core_tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mvsp_pkg.sv
rtl/mvsp_bit_step.sv
rtl/mvsp_byte_unit.sv
rtl/mpeg4_vol_size_parser_core.sv
dv/mpeg4_vol_size_parser_core_tb.sv
